>>> rtl/pxac_pkg.sv
package pxac_pkg;

    // Sizes of the position counters and the image.
    localparam int MAX_SIZE  = 16384;
    localparam int COL_W     = 14;
    localparam int ROW_W     = 14;
    localparam int WIDTH_W   = 15;
    localparam int EDGE_W    = 16;
    localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(16383);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_LEFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_TOP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_COLS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_ROWS  = 3'd6;

    // Pixel formats.
    localparam logic [1:0] FMT_GRAY      = 2'd0;
    localparam logic [1:0] FMT_RGB       = 2'd1;
    localparam logic [1:0] FMT_CMYK      = 2'd2;
    localparam logic [1:0] FMT_CMYK_INV  = 2'd3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // Queue between classification and conversion.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]         pixel_format;
        logic [WIDTH_W-1:0] image_width;
        logic               crop_enable;
        logic [COL_W-1:0]   region_left;
        logic [ROW_W-1:0]   region_top;
        logic [WIDTH_W-1:0] region_cols;
        logic [WIDTH_W-1:0] region_rows;
    } t_cfg;

    // One pixel that survived the crop, waiting for conversion.
    typedef struct packed {
        logic [7:0] comp_a;
        logic [7:0] comp_b;
        logic [7:0] comp_c;
        logic [7:0] comp_d;
        logic       row_end;
    } t_job;

    // floor(p / 255) for any p below 65280.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

>>> rtl/pxac_front.sv
module pxac_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pxac_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    input  logic [7:0]           i_comp_a,
    input  logic [7:0]           i_comp_b,
    input  logic [7:0]           i_comp_c,
    input  logic [7:0]           i_comp_d,
    input  logic                 i_frame_start,
    input  logic                 i_full,
    output logic                 o_push,
    output pxac_pkg::t_job       o_job
);

    logic [pxac_pkg::COL_W-1:0]   r_col, n_col;
    logic [pxac_pkg::ROW_W-1:0]   r_row, n_row;
    logic [pxac_pkg::COL_W-1:0]   col_cur;
    logic [pxac_pkg::ROW_W-1:0]   row_cur;
    logic [pxac_pkg::WIDTH_W-1:0] w_eff;
    logic [pxac_pkg::WIDTH_W-1:0] col_inc;
    logic [pxac_pkg::EDGE_W-1:0]  right_sum;
    logic [pxac_pkg::EDGE_W-1:0]  right;
    logic [pxac_pkg::EDGE_W-1:0]  bottom;
    logic                         at_row_end;
    logic                         in_window;
    logic                         emit;
    logic                         last;
    logic                         accept;

    assign accept = i_valid && !i_full;

    always_comb begin
        if (i_cfg.image_width == '0) begin
            w_eff = pxac_pkg::WIDTH_W'(1);
        end else if (i_cfg.image_width > pxac_pkg::WIDTH_W'(pxac_pkg::MAX_SIZE)) begin
            w_eff = pxac_pkg::WIDTH_W'(pxac_pkg::MAX_SIZE);
        end else begin
            w_eff = i_cfg.image_width;
        end
    end

    // A new frame restarts the position before this pixel is classified.
    assign col_cur    = i_frame_start ? '0 : r_col;
    assign row_cur    = i_frame_start ? '0 : r_row;
    assign col_inc    = {1'b0, col_cur} + pxac_pkg::WIDTH_W'(1);
    assign at_row_end = col_inc >= w_eff;

    assign right_sum = {2'b00, i_cfg.region_left} + {1'b0, i_cfg.region_cols};
    assign right     = (right_sum > {1'b0, w_eff}) ? {1'b0, w_eff} : right_sum;
    assign bottom    = {2'b00, i_cfg.region_top} + {1'b0, i_cfg.region_rows};

    assign in_window = (col_cur >= i_cfg.region_left) && ({2'b00, col_cur} < right) &&
                       (row_cur >= i_cfg.region_top) && ({2'b00, row_cur} < bottom);
    assign emit      = !i_cfg.crop_enable || in_window;
    assign last      = i_cfg.crop_enable ? (in_window && ({1'b0, col_inc} == right))
                                         : at_row_end;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (at_row_end) begin
                n_col = '0;
                n_row = (row_cur < pxac_pkg::ROW_LIMIT) ? row_cur + pxac_pkg::ROW_W'(1)
                                                        : row_cur;
            end else begin
                n_col = col_inc[pxac_pkg::COL_W-1:0];
                n_row = row_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_push        = accept && emit;
    assign o_job.comp_a  = i_comp_a;
    assign o_job.comp_b  = i_comp_b;
    assign o_job.comp_c  = i_comp_c;
    assign o_job.comp_d  = i_comp_d;
    assign o_job.row_end = last;

endmodule

>>> rtl/pxac_queue.sv
module pxac_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pxac_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output pxac_pkg::t_job o_job
);

    pxac_pkg::t_job                r_slot [pxac_pkg::QUEUE_DEPTH];
    logic [pxac_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [pxac_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [pxac_pkg::QUEUE_CW-1:0] r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = r_count == pxac_pkg::QUEUE_CW'(pxac_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + pxac_pkg::QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + pxac_pkg::QUEUE_AW'(1);
            end
            r_count <= r_count + pxac_pkg::QUEUE_CW'(do_push) - pxac_pkg::QUEUE_CW'(do_pop);
        end
    end

endmodule

>>> rtl/pxac_back.sv
module pxac_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_pixel_format,
    input  logic           i_empty,
    input  pxac_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [31:0]    o_argb_pixel,
    output logic           o_row_end
);

    logic        r_s1_valid;
    logic [15:0] r_s1_prod_r, r_s1_prod_g, r_s1_prod_b;
    logic [7:0]  r_s1_a, r_s1_b, r_s1_c;
    logic        r_s1_last;
    logic        r_out_valid;
    logic [31:0] r_out_pixel;
    logic        r_out_last;

    logic        s1_load;
    logic        out_load;
    logic        cmyk;
    logic [7:0]  op_a, op_b, op_c, op_d;
    logic [7:0]  red, green, blue;

    assign out_load = !r_out_valid || !i_stall;
    assign s1_load  = !r_s1_valid || out_load;
    assign o_pop    = s1_load && !i_empty;

    // Plain CMYK works on the complements, the inverted form on the raw bytes.
    assign cmyk = i_pixel_format == pxac_pkg::FMT_CMYK;
    assign op_a = cmyk ? ~i_job.comp_a : i_job.comp_a;
    assign op_b = cmyk ? ~i_job.comp_b : i_job.comp_b;
    assign op_c = cmyk ? ~i_job.comp_c : i_job.comp_c;
    assign op_d = cmyk ? ~i_job.comp_d : i_job.comp_d;

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_prod_r <= op_a * op_d;
            r_s1_prod_g <= op_b * op_d;
            r_s1_prod_b <= op_c * op_d;
            r_s1_a      <= i_job.comp_a;
            r_s1_b      <= i_job.comp_b;
            r_s1_c      <= i_job.comp_c;
            r_s1_last   <= i_job.row_end;
        end
    end

    always_comb begin
        unique case (i_pixel_format)
            pxac_pkg::FMT_GRAY: begin
                red   = r_s1_a;
                green = r_s1_a;
                blue  = r_s1_a;
            end
            pxac_pkg::FMT_RGB: begin
                red   = r_s1_a;
                green = r_s1_b;
                blue  = r_s1_c;
            end
            default: begin
                red   = pxac_pkg::div255(r_s1_prod_r);
                green = pxac_pkg::div255(r_s1_prod_g);
                blue  = pxac_pkg::div255(r_s1_prod_b);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out_pixel <= {pxac_pkg::ALPHA_OPAQUE, red, green, blue};
            r_out_last  <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= !i_empty;
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_argb_pixel = r_out_pixel;
    assign o_row_end    = r_out_last;

endmodule

>>> rtl/pixel_to_argb_crop.sv
// Pixel to ARGB8888 converter with an optional crop window.
// The input channel takes one decoded pixel per item in raster order:
// up to four component bytes and a frame start flag that restarts the
// column and row counters. The output channel gives one opaque ARGB8888
// word per emitted pixel plus a flag on the last pixel of each output row.
// Both channels use valid and stall; an item moves at an edge where valid
// is high and stall is low. Registers are written on a separate port with
// valid and ready, where ready is always high.
// An accepted item is written to the queue, then passes the stage one
// register and the output register before its result shows on the output.
// Throughput is one item per cycle while the output does not stall, set by
// the front classifier that handles one pixel a cycle and the two stage
// multiply and divide-by-255 pipeline behind it.
// Reset clears the counters, the queue and the output valid, and loads the
// registers with RGB format, width one and cropping off.
// When the receiver stalls, the output word holds, the pipeline fills, then
// the four entry queue fills, and only then the input stall rises.
module pixel_to_argb_crop (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pxac_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pxac_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Pixel input.
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [7:0]                         i_comp_a,
    input  logic [7:0]                         i_comp_b,
    input  logic [7:0]                         i_comp_c,
    input  logic [7:0]                         i_comp_d,
    input  logic                               i_frame_start,
    // ARGB output.
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [31:0]                        o_argb_pixel,
    output logic                               o_row_end
);

    pxac_pkg::t_cfg r_cfg;
    pxac_pkg::t_job front_job;
    pxac_pkg::t_job queue_job;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;

    // The register file accepts a write every cycle. Indexes past the list
    // are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_format <= pxac_pkg::FMT_RGB;
            r_cfg.image_width  <= pxac_pkg::WIDTH_W'(1);
            r_cfg.crop_enable  <= 1'b0;
            r_cfg.region_left  <= '0;
            r_cfg.region_top   <= '0;
            r_cfg.region_cols  <= '0;
            r_cfg.region_rows  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pxac_pkg::CFG_PIXEL_FORMAT: r_cfg.pixel_format <= i_cfg_data[1:0];
                pxac_pkg::CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data;
                pxac_pkg::CFG_CROP_ENABLE:  r_cfg.crop_enable  <= i_cfg_data[0];
                pxac_pkg::CFG_REGION_LEFT:  r_cfg.region_left  <= i_cfg_data[13:0];
                pxac_pkg::CFG_REGION_TOP:   r_cfg.region_top   <= i_cfg_data[13:0];
                pxac_pkg::CFG_REGION_COLS:  r_cfg.region_cols  <= i_cfg_data;
                pxac_pkg::CFG_REGION_ROWS:  r_cfg.region_rows  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front tracks the position and decides which pixels survive the
    // crop; dropped pixels never enter the queue.
    pxac_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .i_comp_a     (i_comp_a),
        .i_comp_b     (i_comp_b),
        .i_comp_c     (i_comp_c),
        .i_comp_d     (i_comp_d),
        .i_frame_start(i_frame_start),
        .i_full       (full),
        .o_push       (push),
        .o_job        (front_job)
    );

    // The queue lets the front keep taking pixels while the output stalls.
    pxac_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (front_job),
        .i_pop  (pop),
        .o_full (full),
        .o_empty(empty),
        .o_job  (queue_job)
    );

    // The back multiplies in one stage, divides by 255 and packs in the next.
    pxac_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_format(r_cfg.pixel_format),
        .i_empty       (empty),
        .i_job         (queue_job),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_argb_pixel  (o_argb_pixel),
        .o_row_end     (o_row_end)
    );

    assign o_stall = full;

endmodule

>>> rtl/pxac_checker.sv
module pxac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_argb_pixel,
    input logic        o_row_end
);

    // Reset empties the output register.
    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Reset empties the queue, so the input is open right after it.
    a_reset_opens_input: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

    // Every result is opaque.
    a_alpha_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_argb_pixel[31:24] == 8'hff)
        else $error("alpha not opaque");

    // A stalled result holds.
    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_argb_pixel) && $stable(o_row_end))
        else $error("stalled result changed");

endmodule

bind pixel_to_argb_crop pxac_checker u_pxac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_argb_pixel(o_argb_pixel),
    .o_row_end   (o_row_end)
);

>>> tb/pixel_to_argb_crop_tb.sv
module pixel_to_argb_crop_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pxac_pkg::*;

    // Largest channel value, used by both CMYK conversions.
    localparam int unsigned CHANNEL_MAX    = 255;
    // Cycles to let pass after the last expected item, so that a pixel that
    // is cropped away has left the pipeline before a register changes.
    localparam int unsigned SETTLE_CYCLES  = 12;
    // Length of the long receiver hold that fills the block up.
    localparam int unsigned HOLD_CYCLES    = 80;
    // Cycles without any handshake before the run is declared hung.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_PHASES  = 8;
    localparam int unsigned PHASE_ITEMS    = 100;
    localparam int unsigned FRAME_CAP      = 120;

    typedef struct {
        logic [7:0] comp_a;
        logic [7:0] comp_b;
        logic [7:0] comp_c;
        logic [7:0] comp_d;
        logic       frame_start;
    } t_pixel;

    typedef struct {
        logic [31:0] argb;
        logic        row_end;
    } t_argb_word;

    // Clock, reset and all block inputs start at known values.
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_valid       = 1'b0;
    logic                  o_stall;
    logic [7:0]            i_comp_a      = '0;
    logic [7:0]            i_comp_b      = '0;
    logic [7:0]            i_comp_c      = '0;
    logic [7:0]            i_comp_d      = '0;
    logic                  i_frame_start = 1'b0;
    logic                  o_valid;
    logic                  i_stall       = 1'b0;
    logic [31:0]           o_argb_pixel;
    logic                  o_row_end;

    // Local copy of the register file, mirrored on every write.
    logic [1:0]            cfg_format = FMT_RGB;
    logic [WIDTH_W-1:0]    cfg_width  = WIDTH_W'(1);
    logic                  cfg_crop   = 1'b0;
    logic [COL_W-1:0]      cfg_left   = '0;
    logic [ROW_W-1:0]      cfg_top    = '0;
    logic [WIDTH_W-1:0]    cfg_cols   = '0;
    logic [WIDTH_W-1:0]    cfg_rows   = '0;

    // Predicted pixel position, the same counters the block keeps.
    logic [COL_W-1:0]      pred_col = '0;
    logic [ROW_W-1:0]      pred_row = '0;

    t_pixel                pixel_q[$];
    t_argb_word            expected_argb_q[$];

    int unsigned items_pushed   = 0;
    int unsigned items_accepted = 0;
    int unsigned words_checked  = 0;
    int unsigned fail_count     = 0;
    int unsigned idle_cycles    = 0;

    // Sender state: current item, burst and gap bookkeeping.
    t_pixel      tx_item;
    bit          tx_accepted   = 1'b0;
    bit          tx_steady     = 1'b0;
    int unsigned tx_gap        = 0;
    int unsigned tx_burst_left = 1;

    // Receiver state: stall pattern and the long hold request.
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned rx_hold_left  = 0;
    int unsigned rx_mode       = 0;
    int unsigned rx_mode_left  = 0;
    int unsigned rx_tick       = 0;

    pixel_to_argb_crop u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_comp_a      (i_comp_a),
        .i_comp_b      (i_comp_b),
        .i_comp_c      (i_comp_c),
        .i_comp_d      (i_comp_d),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_argb_pixel  (o_argb_pixel),
        .o_row_end     (o_row_end)
    );

    always #10 i_clk = ~i_clk;

    // Works out the ARGB word (if any) that one accepted pixel produces and
    // advances the position counters. The width is clamped to the counter
    // span, and the row counter sticks at its limit once it gets there.
    task automatic predict_argb(input t_pixel px);
        int unsigned w, col, row, right_edge, red, green, blue;
        int unsigned ca, cb, cc, cd;
        bit          emit, last;
        t_argb_word  word;
        ca = px.comp_a;
        cb = px.comp_b;
        cc = px.comp_c;
        cd = px.comp_d;
        w = (cfg_width == 0) ? 1 : cfg_width;
        if (w > MAX_SIZE) w = MAX_SIZE;
        if (px.frame_start) begin
            pred_col = '0;
            pred_row = '0;
        end
        col = pred_col;
        row = pred_row;
        if (cfg_crop) begin
            right_edge = cfg_left + cfg_cols;
            if (right_edge > w) right_edge = w;
            emit = (col >= cfg_left) && (col < right_edge) &&
                   (row >= cfg_top) && (row < cfg_top + cfg_rows);
            last = emit && (col + 1 == right_edge);
        end else begin
            emit = 1'b1;
            last = (col + 1 >= w);
        end
        if (col + 1 >= w) begin
            pred_col = '0;
            if (pred_row < ROW_LIMIT) pred_row = pred_row + ROW_W'(1);
        end else begin
            pred_col = COL_W'(col + 1);
        end
        if (emit) begin
            case (cfg_format)
                FMT_GRAY: begin
                    red = ca;
                    green = ca;
                    blue = ca;
                end
                FMT_RGB: begin
                    red = ca;
                    green = cb;
                    blue = cc;
                end
                FMT_CMYK: begin
                    red   = ((CHANNEL_MAX - ca) * (CHANNEL_MAX - cd)) / CHANNEL_MAX;
                    green = ((CHANNEL_MAX - cb) * (CHANNEL_MAX - cd)) / CHANNEL_MAX;
                    blue  = ((CHANNEL_MAX - cc) * (CHANNEL_MAX - cd)) / CHANNEL_MAX;
                end
                default: begin
                    red   = (ca * cd) / CHANNEL_MAX;
                    green = (cb * cd) / CHANNEL_MAX;
                    blue  = (cc * cd) / CHANNEL_MAX;
                end
            endcase
            word.argb    = {ALPHA_OPAQUE, red[7:0], green[7:0], blue[7:0]};
            word.row_end = last;
            expected_argb_q.push_back(word);
        end
    endtask

    // Writes one register through the configuration port and mirrors the
    // masked value into the local register copy once the write is taken.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_PIXEL_FORMAT: cfg_format = data[1:0];
            CFG_IMAGE_WIDTH:  cfg_width  = data[WIDTH_W-1:0];
            CFG_CROP_ENABLE:  cfg_crop   = data[0];
            CFG_REGION_LEFT:  cfg_left   = data[COL_W-1:0];
            CFG_REGION_TOP:   cfg_top    = data[ROW_W-1:0];
            CFG_REGION_COLS:  cfg_cols   = data[WIDTH_W-1:0];
            CFG_REGION_ROWS:  cfg_rows   = data[WIDTH_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Loads the whole register set. The format and crop writes carry random
    // junk in their unused upper bits, which the block must ignore.
    task automatic load_window(input logic [1:0] fmt, input int unsigned width,
                               input bit crop, input int unsigned left,
                               input int unsigned top, input int unsigned cols,
                               input int unsigned rows);
        write_reg(CFG_PIXEL_FORMAT, ($urandom & 32'h7ffc) | fmt);
        write_reg(CFG_IMAGE_WIDTH, width);
        write_reg(CFG_CROP_ENABLE, ($urandom & 32'h7ffe) | crop);
        write_reg(CFG_REGION_LEFT, left);
        write_reg(CFG_REGION_TOP, top);
        write_reg(CFG_REGION_COLS, cols);
        write_reg(CFG_REGION_ROWS, rows);
    endtask

    task automatic push_bytes(input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] c, input logic [7:0] d,
                              input logic fs);
        t_pixel px;
        px.comp_a      = a;
        px.comp_b      = b;
        px.comp_c      = c;
        px.comp_d      = d;
        px.frame_start = fs;
        pixel_q.push_back(px);
        items_pushed++;
    endtask

    // Random byte, pulled toward the extremes now and then.
    function automatic logic [7:0] pick_byte();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 8'h00;
        if (sel == 1) return 8'hff;
        return 8'($urandom);
    endfunction

    // Picks a random register set and queues whole frames that match its
    // width. Most frames are clean; some carry a stray frame start in the
    // middle, and a few are short bursts of noise.
    task automatic run_random_phase(input bit allow_crop);
        int unsigned w, w_eff, span, pick, pushed, frame_len, k;
        pick = $urandom_range(0, 19);
        if (pick == 0) w = 0;
        else if (pick == 1) w = $urandom_range(MAX_SIZE, 32767);
        else w = $urandom_range(1, 12);
        w_eff = (w == 0) ? 1 : ((w > MAX_SIZE) ? MAX_SIZE : w);
        span = (w_eff > 12) ? 12 : w_eff;
        load_window(2'($urandom_range(0, 3)), w,
                    allow_crop && ($urandom_range(0, 2) != 0),
                    $urandom_range(0, span), $urandom_range(0, 3),
                    $urandom_range(0, span + 2), $urandom_range(0, 5));
        pushed = 0;
        while (pushed < PHASE_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                frame_len = $urandom_range(1, 20);
                for (k = 0; k < frame_len; k++)
                    push_bytes(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                               1'($urandom_range(0, 1)));
            end else begin
                frame_len = w_eff * $urandom_range(1, 6);
                if (frame_len > FRAME_CAP) frame_len = FRAME_CAP;
                for (k = 0; k < frame_len; k++)
                    push_bytes(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                               (k == 0) || ($urandom_range(0, 59) == 0));
            end
            pushed += frame_len;
        end
    endtask

    // Waits until every queued pixel went in and every expected word came
    // out, then lets the pipeline settle before registers may change.
    task automatic wait_idle();
        while (items_accepted != items_pushed || expected_argb_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Input side, edge half: a pixel is taken when valid is high and stall
    // is low. Each taken pixel is fed to the predictor, and the burst and
    // gap pattern of the sender moves on.
    always @(posedge i_clk) begin : pixel_accept
        int unsigned gap_pick;
        tx_accepted = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            tx_accepted = 1'b1;
            predict_argb(tx_item);
            items_accepted++;
            if (tx_burst_left > 1) begin
                tx_burst_left--;
            end else begin
                tx_burst_left = $urandom_range(1, 24);
                tx_gap = 0;
                if (!tx_steady) begin
                    gap_pick = $urandom_range(0, 7);
                    if (gap_pick == 7) tx_gap = $urandom_range(10, 20);
                    else if (gap_pick >= 3) tx_gap = $urandom_range(1, 4);
                end
            end
        end
    end

    // Input side, driving half: a pixel on offer stays put until it is
    // taken. Only then may the sender go quiet for a gap or offer the next.
    always @(negedge i_clk) begin : pixel_driver
        if (!i_valid || tx_accepted) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                tx_item = pixel_q.pop_front();
                i_comp_a      <= tx_item.comp_a;
                i_comp_b      <= tx_item.comp_b;
                i_comp_c      <= tx_item.comp_c;
                i_comp_d      <= tx_item.comp_d;
                i_frame_start <= tx_item.frame_start;
                i_valid       <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output side stall pattern. It switches between free flow, coin flips,
    // a fixed one in three pattern and heavy stalling. A hold request from
    // the stimulus makes it stall solidly for a long stretch.
    always @(negedge i_clk) begin : argb_receiver
        rx_tick++;
        if (hold_served != hold_requests) begin
            hold_served  = hold_requests;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 200);
        end else begin
            rx_mode_left--;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_stall <= 1'b1;
        end else begin
            case (rx_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= 1'($urandom_range(0, 1));
                2:       i_stall <= (rx_tick % 3 == 0);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Checks every taken ARGB word against the oldest prediction.
    always @(posedge i_clk) begin : argb_monitor
        t_argb_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            words_checked++;
            if (expected_argb_q.size() == 0) begin
                $error("unexpected output item: argb_pixel %h row_end %b",
                       o_argb_pixel, o_row_end);
                fail_count++;
            end else begin
                want = expected_argb_q.pop_front();
                if (o_argb_pixel !== want.argb) begin
                    $error("argb_pixel mismatch: expected %h, actual %h",
                           want.argb, o_argb_pixel);
                    fail_count++;
                end
                if (o_row_end !== want.row_end) begin
                    $error("row_end mismatch: expected %b, actual %b",
                           want.row_end, o_row_end);
                    fail_count++;
                end
            end
        end
    end

    // Ends a hung run. Any handshake on any channel counts as progress.
    always @(posedge i_clk) begin : watchdog
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned ph, k;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: RGB, width one, no crop. Every pixel ends a row.
        push_bytes(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        push_bytes(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
        push_bytes(8'ha5, 8'h5a, 8'hc3, 8'h3c, 1'b0);
        wait_idle();

        // Gray with a zero width, which the block treats as width one. The
        // other bytes must not leak into the output.
        load_window(FMT_GRAY, 0, 1'b0, 0, 0, 0, 0);
        push_bytes(8'h80, 8'h12, 8'h34, 8'h56, 1'b1);
        push_bytes(8'hff, 8'h00, 8'h00, 8'h00, 1'b0);
        wait_idle();

        // CMYK at the corners of the byte range, rows of three.
        load_window(FMT_CMYK, 3, 1'b0, 0, 0, 0, 0);
        push_bytes(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        push_bytes(8'hff, 8'hff, 8'hff, 8'h00, 1'b0);
        push_bytes(8'h00, 8'h80, 8'hff, 8'hff, 1'b0);
        push_bytes(8'h01, 8'h7f, 8'hfe, 8'h80, 1'b0);
        wait_idle();

        // Inverted CMYK with the largest width register, clamped to the
        // counter span, so no pixel here ends a row.
        load_window(FMT_CMYK_INV, 32767, 1'b0, 0, 0, 0, 0);
        push_bytes(8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
        push_bytes(8'h00, 8'h80, 8'hff, 8'hff, 1'b0);
        push_bytes(8'hff, 8'h01, 8'h80, 8'h7f, 1'b0);
        wait_idle();

        // A window that runs past the right and bottom edges of the image
        // gets clipped; only columns two and three of the second row come out.
        load_window(FMT_RGB, 4, 1'b1, 2, 1, 32767, 32767);
        for (k = 0; k < 8; k++)
            push_bytes(pick_byte(), pick_byte(), pick_byte(), pick_byte(), k == 0);
        wait_idle();

        // An empty window that also starts beyond the image emits nothing.
        // The upper data bit is set on left and top and must be dropped.
        load_window(FMT_GRAY, 4, 1'b1, 32'h7fff, 32'h7fff, 0, 0);
        push_bytes(8'h11, 8'h22, 8'h33, 8'h44, 1'b1);
        push_bytes(8'hee, 8'hdd, 8'hcc, 8'hbb, 1'b0);
        push_bytes(8'h7f, 8'h80, 8'h01, 8'hfe, 1'b0);
        wait_idle();

        // Random register sets with frame-shaped traffic. One phase runs the
        // sender flat out with cropping off while the receiver holds off for
        // a long stretch, so the block fills and has to stall its input.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 2) begin
                tx_steady = 1'b1;
                run_random_phase(1'b0);
                hold_requests++;
                wait_idle();
                tx_steady = 1'b0;
            end else begin
                run_random_phase(1'b1);
                wait_idle();
            end
        end

        $display("run covered %0d pixel items and %0d ARGB words in all four formats",
                 items_accepted, words_checked);
        $display("including clipped, empty and offset windows and a long output hold");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> pixel_to_argb_crop.f
rtl/pxac_pkg.sv
rtl/pxac_front.sv
rtl/pxac_queue.sv
rtl/pxac_back.sv
rtl/pixel_to_argb_crop.sv
rtl/pxac_checker.sv
tb/pixel_to_argb_crop_tb.sv
